// ===== src/sdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the step detector with cadence estimate.
// No dependencies; imported by sdc_div, step_detector_cadence_core and the testbench.
package sdc_pkg;

   // field and register widths
   localparam int ACCEL_W      = 16;
   localparam int TIME_W       = 32;
   localparam int THR_W        = 15;
   localparam int INTV_W       = 16;
   localparam int STEP_COUNT_W = 24;
   localparam int CAD_W        = 17;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   // step counter width default (allowed 8..32)
   localparam int COUNT_WIDTH_DEF = 24;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_MARGIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL_MS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INTERVAL_MS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT_MS = 3'd4;

   // register reset values
   localparam logic [THR_W-1:0]  PEAK_THRESHOLD_RST  = 15'd3072;
   localparam logic [THR_W-1:0]  RELEASE_MARGIN_RST  = 15'd256;
   localparam logic [INTV_W-1:0] MIN_INTERVAL_RST    = 16'd200;
   localparam logic [INTV_W-1:0] MAX_INTERVAL_RST    = 16'd3000;
   localparam logic [INTV_W-1:0] IDLE_TIMEOUT_RST    = 16'd2500;

   // shared multiplier: 17 x 17 unsigned, product kept to 32 bits
   localparam int MUL_W  = 17;
   localparam int PROD_W = 32;

   // cadence arithmetic
   localparam int                 DIV_W     = 24;
   localparam logic [DIV_W-1:0]   DIV_NUMER = 24'd15360000; // 60000 * 256
   localparam logic [CAD_W-1:0]   CAD_MAX   = 17'd131071;
   localparam logic [MUL_W-1:0]   W_OLD     = 17'd179;
   localparam logic [MUL_W-1:0]   W_NEW     = 17'd77;
   localparam logic [PROD_W-1:0]  AVG_ROUND = 32'd128;

   typedef struct packed {
      logic busy;
      logic done;
   } sdc_div_stat_type;

endpackage

// ===== src/step_detector_cadence_core.sv =====
`timescale 1ns / 1ps
// Step detector core: each sample passes capture, the three squares, the threshold and re-arm
// level squares and the step decision; when a cadence update is due, the serial divide and two
// averaging products follow. A new sample is taken only in idle; req_stall is high outside idle.
// All work goes through one shared 17x17 multiplier and the serial divider sdc_div.
// Reset (synchronous, active high) restores register defaults, arms the detector, and
// clears the step count, last step time and cadence.
module step_detector_cadence_core #(
   parameter int COUNT_WIDTH = sdc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_we,
   input  logic [sdc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sdc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   // sample channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [sdc_pkg::ACCEL_W-1:0]    req_accel_x,
   input  logic signed [sdc_pkg::ACCEL_W-1:0]    req_accel_y,
   input  logic signed [sdc_pkg::ACCEL_W-1:0]    req_accel_z,
   input  logic [sdc_pkg::TIME_W-1:0]            req_time_ms,
   input  logic                                  req_clear_count,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_stepped,
   output logic [sdc_pkg::STEP_COUNT_W-1:0]      rsp_step_count,
   output logic [sdc_pkg::CAD_W-1:0]             rsp_cadence
);
   import sdc_pkg::*;

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_MUL    = 7'b0000010,
      S_ACC    = 7'b0000100,
      S_DECIDE = 7'b0001000,
      S_DIV    = 7'b0010000,
      S_AVG    = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   // multiplier operation codes
   typedef enum logic [2:0] {
      MI_X   = 3'd0,   // x*x
      MI_Y   = 3'd1,   // y*y
      MI_Z   = 3'd2,   // z*z
      MI_THR = 3'd3,   // threshold squared
      MI_LVL = 3'd4,   // re-arm level squared
      MI_OLD = 3'd5,   // 179 * old cadence
      MI_NEW = 3'd6    // 77 * instantaneous cadence
   } mul_op_type;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // configuration registers
   logic [THR_W-1:0]  peak_thr_ff;
   logic [THR_W-1:0]  margin_ff;
   logic [INTV_W-1:0] min_intv_ff;
   logic [INTV_W-1:0] max_intv_ff;
   logic [INTV_W-1:0] idle_to_ff;

   // sequencer and datapath
   state_type          state_ff, state_in;
   mul_op_type         op_ff, op_in;
   logic [ACCEL_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;      // mag^2, later the cadence average sum
   logic [PROD_W-1:0]  thr2_ff, thr2_in;
   logic [PROD_W-1:0]  lvl2_ff, lvl2_in;
   logic [CAD_W-1:0]   inst_ff, inst_in;
   logic               stepped_ff, stepped_in;

   // detector state
   logic                   latched_ff, latched_in;
   logic [COUNT_WIDTH-1:0] steps_ff, steps_in;
   logic [TIME_W-1:0]      last_ff, last_in;
   logic                   have_last_ff, have_last_in;
   logic [CAD_W-1:0]       cad_ff, cad_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_stepped_ff, rsp_stepped_in;
   logic [STEP_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [CAD_W-1:0]        rsp_cad_ff, rsp_cad_in;

   // shared multiplier
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [2*MUL_W-1:0] mul_p;

   // divider hookup
   logic                 div_start;
   logic [DIV_W-1:0]     div_dividend;
   logic [INTV_W-1:0]    div_divisor;
   sdc_div_stat_type     div_stat;
   logic [DIV_W-1:0]     div_quo;

   // decision helpers
   logic              req_xfer, rsp_xfer;
   logic [TIME_W-1:0] since_last;
   logic              hit, go_div, rearm_en;
   logic [THR_W-1:0]  lvl;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;

   // magnitudes of the signed samples, 17 bits so that -32768 fits
   function automatic logic [MUL_W-1:0] mag17(input logic [ACCEL_W-1:0] v);
      logic [MUL_W-1:0] ext;
      ext = {v[ACCEL_W-1], v};
      return v[ACCEL_W-1] ? (MUL_W'(0) - ext) : ext;
   endfunction

   assign rearm_en = margin_ff < peak_thr_ff;
   assign lvl      = peak_thr_ff - margin_ff;

   always_comb begin
      case (op_ff)
         MI_X: begin
            mul_a = mag17(x_ff);
            mul_b = mag17(x_ff);
         end
         MI_Y: begin
            mul_a = mag17(y_ff);
            mul_b = mag17(y_ff);
         end
         MI_Z: begin
            mul_a = mag17(z_ff);
            mul_b = mag17(z_ff);
         end
         MI_THR: begin
            mul_a = MUL_W'(peak_thr_ff);
            mul_b = MUL_W'(peak_thr_ff);
         end
         MI_LVL: begin
            mul_a = MUL_W'(lvl);
            mul_b = MUL_W'(lvl);
         end
         MI_OLD: begin
            mul_a = W_OLD;
            mul_b = cad_ff;
         end
         MI_NEW: begin
            mul_a = W_NEW;
            mul_b = inst_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // step decision terms, valid in S_DECIDE once all squares are in
   assign since_last   = now_ff - last_ff;
   assign hit          = (acc_ff > thr2_ff) && !latched_ff;
   assign go_div       = hit && have_last_ff
                         && (since_last > TIME_W'(min_intv_ff))
                         && (since_last < TIME_W'(max_intv_ff));
   assign div_start    = (state_ff == S_DECIDE) && go_div;
   // round half up: (60000*256 + d/2) / d; the interval is below 2^16 here
   assign div_dividend = DIV_NUMER + DIV_W'(since_last[INTV_W-1:1]);
   assign div_divisor  = since_last[INTV_W-1:0];

   sdc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      now_in         = now_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      thr2_in        = thr2_ff;
      lvl2_in        = lvl2_ff;
      inst_in        = inst_ff;
      stepped_in     = stepped_ff;
      latched_in     = latched_ff;
      steps_in       = steps_ff;
      last_in        = last_ff;
      have_last_in   = have_last_ff;
      cad_in         = cad_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_xfer;
      rsp_stepped_in = rsp_stepped_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_cad_in     = rsp_cad_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               // capture the sample; clear the count before it is handled
               x_in       = req_accel_x;
               y_in       = req_accel_y;
               z_in       = req_accel_z;
               now_in     = req_time_ms;
               stepped_in = 1'b0;
               op_in      = MI_X;
               if (req_clear_count) begin
                  steps_in = '0;
               end
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = mul_p[PROD_W-1:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            // route the registered product to its destination, advance the op
            state_in = S_MUL;
            op_in    = mul_op_type'(op_ff + 3'd1);
            case (op_ff)
               MI_X:   acc_in  = prod_ff;
               MI_Y:   acc_in  = acc_ff + prod_ff;
               MI_Z:   acc_in  = acc_ff + prod_ff;
               MI_THR: thr2_in = prod_ff;
               MI_LVL: begin
                  lvl2_in  = prod_ff;
                  state_in = S_DECIDE;
               end
               MI_OLD: acc_in = prod_ff;
               MI_NEW: begin
                  acc_in   = acc_ff + prod_ff;
                  state_in = S_AVG;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_DECIDE: begin
            if (hit) begin
               latched_in   = 1'b1;
               stepped_in   = 1'b1;
               last_in      = now_ff;
               have_last_in = 1'b1;
               if (steps_ff != COUNT_MAX) begin
                  steps_in = steps_ff + 1'b1;
               end
            end else if (since_last > TIME_W'(idle_to_ff)) begin
               // idle timeout: no step for too long; a fresh step never times out
               cad_in = '0;
            end
            // re-arm uses the final latch value of this sample
            if (rearm_en && (acc_ff < lvl2_ff)) begin
               latched_in = 1'b0;
            end
            state_in = go_div ? S_DIV : S_DONE;
         end
         S_DIV: begin
            if (div_stat.done) begin
               inst_in  = (div_quo > DIV_W'(CAD_MAX)) ? CAD_MAX : div_quo[CAD_W-1:0];
               op_in    = MI_OLD;
               state_in = S_MUL;
            end
         end
         S_AVG: begin
            // (179*old + 77*inst + 128) >> 8
            acc_in   = acc_ff + AVG_ROUND;
            cad_in   = CAD_W'((acc_ff + AVG_ROUND) >> 8);
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_stepped_in = stepped_ff;
               rsp_count_in   = STEP_COUNT_W'(steps_ff);
               rsp_cad_in     = cad_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_thr_ff <= PEAK_THRESHOLD_RST;
         margin_ff   <= RELEASE_MARGIN_RST;
         min_intv_ff <= MIN_INTERVAL_RST;
         max_intv_ff <= MAX_INTERVAL_RST;
         idle_to_ff  <= IDLE_TIMEOUT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PEAK_THRESHOLD:  peak_thr_ff <= csr_wdata[THR_W-1:0];
            CSR_RELEASE_MARGIN:  margin_ff   <= csr_wdata[THR_W-1:0];
            CSR_MIN_INTERVAL_MS: min_intv_ff <= csr_wdata[INTV_W-1:0];
            CSR_MAX_INTERVAL_MS: max_intv_ff <= csr_wdata[INTV_W-1:0];
            CSR_IDLE_TIMEOUT_MS: idle_to_ff  <= csr_wdata[INTV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= MI_X;
         latched_ff   <= 1'b0;
         steps_ff     <= '0;
         last_ff      <= '0;
         have_last_ff <= 1'b0;
         cad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         latched_ff   <= latched_in;
         steps_ff     <= steps_in;
         last_ff      <= last_in;
         have_last_ff <= have_last_in;
         cad_ff       <= cad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff           <= x_in;
      y_ff           <= y_in;
      z_ff           <= z_in;
      now_ff         <= now_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      thr2_ff        <= thr2_in;
      lvl2_ff        <= lvl2_in;
      inst_ff        <= inst_in;
      stepped_ff     <= stepped_in;
      rsp_stepped_ff <= rsp_stepped_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_cad_ff     <= rsp_cad_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_stepped    = rsp_stepped_ff;
   assign rsp_step_count = rsp_count_ff;
   assign rsp_cadence    = rsp_cad_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside the done state");
   a_div_running: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> div_stat.busy || div_stat.done)
      else $error("waiting on an idle divider");
   a_squares_then_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC && op_ff == MI_LVL) |=> state_ff == S_DECIDE)
      else $error("decision not taken after the squares");

endmodule

// ===== src/sdc_div.sv =====
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle.
// Depends on sdc_pkg for widths and the status struct.
module sdc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sdc_pkg::DIV_W-1:0]     dividend,
   input  logic [sdc_pkg::INTV_W-1:0]    divisor,
   output sdc_pkg::sdc_div_stat_type     stat,
   output logic [sdc_pkg::DIV_W-1:0]     quotient
);
   import sdc_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [INTV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [INTV_W-1:0] dsr_ff, dsr_in;

   logic [INTV_W:0]   shifted;
   logic [INTV_W:0]   diff;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[INTV_W-1:0] : shifted[INTV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not start");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("done without a finished division");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= CNT_LAST)
      else $error("divider bit count out of range");

endmodule

// ===== tb/step_detector_cadence_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for step_detector_cadence_core: drives accelerometer samples,
// predicts step flag, step count and cadence per sample, and compares every result.
// Depends on sdc_pkg and the core RTL only.
module step_detector_cadence_core_tb;
   import sdc_pkg::*;

   // run shape
   localparam int     RESET_CYCLES      = 9;
   localparam int     RSP_HOLD_CYCLES   = 400;
   localparam int     DRAIN_SETTLE      = 4;
   localparam int     END_SETTLE        = 60;
   localparam int     RANDOM_PHASES     = 8;
   localparam int     ITEMS_PER_PHASE   = 250;
   localparam int     MAX_REPORTED      = 10;
   localparam longint TIMEOUT_NS        = 20_000_000;

   // cadence arithmetic, Q9.8 steps per minute
   localparam longint CAD_NUMER = 60000 * 256;
   localparam longint INST_SAT  = 131071;
   localparam longint AVG_OLD   = 179;
   localparam longint AVG_NEW   = 77;
   localparam longint AVG_HALF  = 128;

   // the count saturates at the top of its 24 bits, far beyond what a run can reach
   localparam logic [STEP_COUNT_W-1:0] STEP_COUNT_MAX = '1;

   // register indexes that decode to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_UNUSED  = 3'd7;

   localparam logic [TIME_W-1:0] TIME_NEAR_WRAP = 32'hFFFF_FF00;

   typedef struct packed {
      logic signed [ACCEL_W-1:0] accel_x;
      logic signed [ACCEL_W-1:0] accel_y;
      logic signed [ACCEL_W-1:0] accel_z;
      logic [TIME_W-1:0]         time_ms;
      logic                      clear_count;
   } accel_sample_type;

   typedef struct packed {
      logic                    stepped;
      logic [STEP_COUNT_W-1:0] step_count;
      logic [CAD_W-1:0]        cadence;
   } step_report_type;

   typedef enum int {MAG_LOW, MAG_MID, MAG_HIGH, MAG_NOISE} mag_kind_type;

   // ------------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;

   logic                          req_valid       = 1'b0;
   logic                          req_stall;
   logic signed [ACCEL_W-1:0]     req_accel_x     = '0;
   logic signed [ACCEL_W-1:0]     req_accel_y     = '0;
   logic signed [ACCEL_W-1:0]     req_accel_z     = '0;
   logic [TIME_W-1:0]             req_time_ms     = '0;
   logic                          req_clear_count = 1'b0;

   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_stepped;
   logic [STEP_COUNT_W-1:0]       rsp_step_count;
   logic [CAD_W-1:0]              rsp_cadence;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   step_detector_cadence_core dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .req_time_ms     (req_time_ms),
      .req_clear_count (req_clear_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_stepped     (rsp_stepped),
      .rsp_step_count  (rsp_step_count),
      .rsp_cadence     (rsp_cadence)
   );

   // ------------------------------------------------------------------
   // shadow registers and detector state, as the block holds them
   // ------------------------------------------------------------------
   logic [THR_W-1:0]        reg_thr       = PEAK_THRESHOLD_RST;
   logic [THR_W-1:0]        reg_margin    = RELEASE_MARGIN_RST;
   logic [INTV_W-1:0]       reg_min_intv  = MIN_INTERVAL_RST;
   logic [INTV_W-1:0]       reg_max_intv  = MAX_INTERVAL_RST;
   logic [INTV_W-1:0]       reg_idle      = IDLE_TIMEOUT_RST;

   logic                    det_latched   = 1'b0;
   logic [STEP_COUNT_W-1:0] det_steps     = '0;
   logic [TIME_W-1:0]       det_last_time = '0;
   logic                    det_have_last = 1'b0;
   logic [CAD_W-1:0]        det_cadence   = '0;

   // results still owed by the block, oldest first
   step_report_type report_q[$];

   int   error_count  = 0;
   int   rsp_seen     = 0;
   bit   req_idle_on  = 1'b1;
   bit   rsp_idle_on  = 1'b1;
   bit   rsp_hold_req = 1'b0;
   logic [TIME_W-1:0] walk_time = '0;

   // Advance the detector by one sample and return what the block must report.
   function automatic step_report_type predict_step(input accel_sample_type s);
      longint       ax, ay, az, mag2, thr2, lvl, intv, inst;
      logic [63:0]  avg;
      logic [TIME_W-1:0] delta;
      step_report_type r;
      ax   = $signed(s.accel_x);
      ay   = $signed(s.accel_y);
      az   = $signed(s.accel_z);
      mag2 = ax * ax + ay * ay + az * az;
      thr2 = longint'(reg_thr) * longint'(reg_thr);
      r.stepped = 1'b0;

      // a clear acts before the sample is judged
      if (s.clear_count)
         det_steps = '0;

      if (mag2 > thr2 && !det_latched) begin
         det_latched = 1'b1;
         r.stepped   = 1'b1;
         if (det_steps != STEP_COUNT_MAX)
            det_steps = det_steps + 1'b1;
         if (det_have_last) begin
            delta = s.time_ms - det_last_time;
            if (delta > reg_min_intv && delta < reg_max_intv) begin
               intv = longint'({32'd0, delta});
               inst = (CAD_NUMER + (intv >> 1)) / intv;
               if (inst > INST_SAT)
                  inst = INST_SAT;
               avg = (AVG_OLD * longint'(det_cadence) + AVG_NEW * inst + AVG_HALF) >> 8;
               det_cadence = avg[CAD_W-1:0];
            end
         end
         det_last_time = s.time_ms;
         det_have_last = 1'b1;
      end

      // re-arm only when a positive release level exists and the magnitude drops under it
      if (reg_margin < reg_thr) begin
         lvl = longint'(reg_thr) - longint'(reg_margin);
         if (mag2 < lvl * lvl)
            det_latched = 1'b0;
      end

      delta = s.time_ms - det_last_time;
      if (delta > reg_idle)
         det_cadence = '0;

      r.step_count = det_steps;
      r.cadence    = det_cadence;
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 80);
   endfunction

   function automatic int rand_signed(input int m);
      return int'($urandom_range(0, 2 * m)) - m;
   endfunction

   function automatic accel_sample_type mk_sample(input int x, input int y, input int z,
                                                  input logic [TIME_W-1:0] t, input logic clr);
      accel_sample_type s;
      s.accel_x     = x[ACCEL_W-1:0];
      s.accel_y     = y[ACCEL_W-1:0];
      s.accel_z     = z[ACCEL_W-1:0];
      s.time_ms     = t;
      s.clear_count = clr;
      return s;
   endfunction

   // Build a sample whose magnitude sits in the wanted band for the current registers.
   function automatic accel_sample_type make_sample(input mag_kind_type kind,
                                                    input logic [TIME_W-1:0] t,
                                                    input logic clr);
      int thr, lvl, z;
      thr = reg_thr;
      lvl = (reg_margin < reg_thr) ? thr - int'(reg_margin) : 0;
      case (kind)
         MAG_LOW: begin
            // three components of at most half the release level stay under it
            return mk_sample(rand_signed(lvl / 2), rand_signed(lvl / 2),
                             rand_signed(lvl / 2), t, clr);
         end
         MAG_MID: begin
            // on one axis between release level and threshold, both ends included
            z = $urandom_range(lvl, thr);
            if ($urandom_range(0, 1) != 0)
               z = -z;
            return mk_sample(0, 0, z, t, clr);
         end
         MAG_HIGH: begin
            if (thr < 32767) begin
               z = $urandom_range(thr + 1, 32767);
               if ($urandom_range(0, 1) != 0)
                  z = -z;
            end else begin
               z = -32768;
            end
            return mk_sample(rand_signed(255), rand_signed(255), z, t, clr);
         end
         default: begin
            return mk_sample($urandom, $urandom, $urandom, t, clr);
         end
      endcase
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTED)
         $display("%t ERROR: %s", $realtime, msg);
   endtask

   // ------------------------------------------------------------------
   // sample channel: offer one sample, hold it until the transfer happens
   // ------------------------------------------------------------------
   task automatic send_sample(input accel_sample_type s);
      int gap;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_accel_x     <= s.accel_x;
      req_accel_y     <= s.accel_y;
      req_accel_z     <= s.accel_z;
      req_time_ms     <= s.time_ms;
      req_clear_count <= s.clear_count;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      report_q.push_back(predict_step(s));
   endtask

   // Drop valid and wait until the block has handed back everything it owes.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (report_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   // Leaves csr_we high; the caller lowers it after the last write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_PEAK_THRESHOLD:  reg_thr      = val[THR_W-1:0];
         CSR_RELEASE_MARGIN:  reg_margin   = val[THR_W-1:0];
         CSR_MIN_INTERVAL_MS: reg_min_intv = val[INTV_W-1:0];
         CSR_MAX_INTERVAL_MS: reg_max_intv = val[INTV_W-1:0];
         CSR_IDLE_TIMEOUT_MS: reg_idle     = val[INTV_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] thr, input logic [CSR_DATA_W-1:0] margin,
                               input logic [CSR_DATA_W-1:0] min_i, input logic [CSR_DATA_W-1:0] max_i,
                               input logic [CSR_DATA_W-1:0] idle);
      write_reg(CSR_PEAK_THRESHOLD, thr);
      write_reg(CSR_RELEASE_MARGIN, margin);
      write_reg(CSR_MIN_INTERVAL_MS, min_i);
      write_reg(CSR_MAX_INTERVAL_MS, max_i);
      write_reg(CSR_IDLE_TIMEOUT_MS, idle);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Walk at a cadence: low samples between peaks, a peak once per period, some noise.
   task automatic walk_items(input int n, input int dt_lo, input int dt_hi,
                             input int per_lo, input int per_hi, input int noise_pct);
      int period, elapsed, dt;
      mag_kind_type kind;
      logic [TIME_W-1:0] t;
      logic clr;
      period  = $urandom_range(per_lo, per_hi);
      elapsed = 0;
      repeat (n) begin
         if (int'($urandom_range(0, 99)) < noise_pct) begin
            kind = MAG_NOISE;
            t    = ($urandom_range(0, 1) != 0) ? $urandom : walk_time;
         end else begin
            dt        = $urandom_range(dt_lo, dt_hi);
            walk_time = walk_time + dt;
            elapsed  += dt;
            t         = walk_time;
            if (elapsed >= period) begin
               kind    = MAG_HIGH;
               elapsed = 0;
               if ($urandom_range(0, 3) == 0)
                  period = $urandom_range(per_lo, per_hi);
            end else begin
               kind = ($urandom_range(0, 9) == 0) ? MAG_MID : MAG_LOW;
            end
         end
         clr = ($urandom_range(0, 63) == 0);
         send_sample(make_sample(kind, t, clr));
      end
   endtask

   // ------------------------------------------------------------------
   // result channel: random stalls, plus one long hold on request
   // ------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int n;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            // hold off long enough for the block to fill and stall its input
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else begin
            n = rsp_idle_on ? pick_gap() : 0;
            rsp_stall <= (n != 0);
            if (n > 1)
               repeat (n - 1) @(posedge clock);
         end
      end
   end

   // Compare each result transfer with the oldest prediction.
   always @(posedge clock) begin
      step_report_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.stepped    = rsp_stepped;
         got.step_count = rsp_step_count;
         got.cadence    = rsp_cadence;
         if (report_q.size() == 0) begin
            flag_error($sformatf("result %0d with none expected: stepped=%0b count=%0d cadence=%0d",
                                 rsp_seen, got.stepped, got.step_count, got.cadence));
         end else begin
            want = report_q.pop_front();
            if (got.stepped !== want.stepped || got.step_count !== want.step_count ||
                got.cadence !== want.cadence)
               flag_error($sformatf({"result %0d: expected stepped=%0b count=%0d cadence=%0d,",
                                     " got stepped=%0b count=%0d cadence=%0d"},
                                    rsp_seen, want.stepped, want.step_count, want.cadence,
                                    got.stepped, got.step_count, got.cadence));
         end
         rsp_seen++;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // Reset values: threshold 12.0, re-arm level 11.0, intervals 200..3000, idle 2500.
   task automatic test_reset_defaults();
      send_sample(mk_sample(0, 0, 0, 0, 1'b0));              // zero vector
      send_sample(mk_sample(0, 0, 3072, 50, 1'b0));          // exactly at threshold: no step
      send_sample(mk_sample(0, 0, 3073, 100, 1'b0));         // first step: no cadence yet
      send_sample(mk_sample(0, 0, 3072, 120, 1'b0));         // still latched
      send_sample(mk_sample(0, 0, 2816, 140, 1'b0));         // exactly at re-arm level: latched
      send_sample(mk_sample(0, 0, -2815, 160, 1'b0));        // just under: re-arm
      send_sample(mk_sample(-32768, -32768, -32768, 600, 1'b0)); // largest magnitude, cadence
      send_sample(mk_sample(0, 0, 0, 650, 1'b0));
      send_sample(mk_sample(32767, 0, 0, 800, 1'b0));        // interval equals the minimum
      send_sample(mk_sample(0, 0, 0, 820, 1'b0));
      send_sample(mk_sample(0, 32767, 0, 3800, 1'b0));       // interval equals the maximum
      send_sample(mk_sample(0, 0, 0, 3810, 1'b0));
      send_sample(mk_sample(0, 0, 4000, 4010, 1'b0));        // just above the minimum
      send_sample(mk_sample(0, 0, 0, 4020, 1'b0));
      send_sample(mk_sample(0, 0, 4000, 7009, 1'b0));        // just under the maximum
      send_sample(mk_sample(0, 0, 0, 7100, 1'b1));           // clear without a step
      send_sample(mk_sample(3000, 3000, 0, 7600, 1'b1));     // clear and step together
      send_sample(mk_sample(0, 0, 0, TIME_NEAR_WRAP, 1'b0)); // long idle: cadence zeroed
      send_sample(mk_sample(0, 0, 5000, TIME_NEAR_WRAP + 32'h80, 1'b0));
      send_sample(mk_sample(0, 0, 0, TIME_NEAR_WRAP + 32'hC0, 1'b0));
      send_sample(mk_sample(0, 0, 5000, 32'h180, 1'b0));     // interval across the wrap
      send_sample(mk_sample(0, 0, 0, 32'h200, 1'b0));
      send_sample(mk_sample(0, 0, 5000, 32'h180, 1'b0));     // time runs backward
      send_sample(mk_sample(0, 0, 0, 32'h180, 1'b0));
      send_sample(mk_sample(0, 0, 5000, 32'h180, 1'b0));     // zero interval
      walk_time = 32'h180;
      wait_drain();
   endtask

   // Register extremes, each followed by a short walk.
   task automatic test_register_extremes();
      // threshold zero: any nonzero vector steps, and the detector never re-arms
      program_regs(16'd0, 16'd0, 16'd1, 16'hFFFF, 16'hFFFF);
      walk_items(30, 1, 4, 8, 30, 10);
      wait_drain();

      // top threshold with fast steps: instantaneous cadence saturates
      program_regs(16'h7FFF, 16'd0, 16'd1, 16'hFFFF, 16'hFFFF);
      walk_items(30, 1, 4, 8, 30, 10);
      wait_drain();

      // upper data bit ignored; margin equal to threshold so no re-arm; no window, instant idle
      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
      walk_items(30, 2, 20, 100, 600, 10);
      wait_drain();

      // writes to undecoded indexes must change nothing
      write_reg(CSR_IDX_W'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_UNUSED)),
                CSR_DATA_W'($urandom));
      program_regs(16'h8000 | 16'd2000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'd1);
      walk_items(30, 2, 20, 100, 600, 10);
      wait_drain();

      // re-arm level of one: only the zero vector re-arms
      program_regs(16'd2500, 16'd2499, 16'd100, 16'd2000, 16'd500);
      walk_items(30, 5, 30, 100, 900, 10);
      wait_drain();
   endtask

   // Hold the result side while samples keep coming, so the block backs up its input.
   task automatic test_backpressure();
      program_regs(16'd3072, 16'd256, 16'd200, 16'd3000, 16'd2500);
      req_idle_on  = 1'b0;
      rsp_idle_on  = 1'b0;
      rsp_hold_req = 1'b1;
      walk_items(40, 5, 30, 200, 900, 10);
      wait_drain();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic program_random_regs();
      logic [CSR_DATA_W-1:0] thr, margin, min_i, max_i, idle;
      thr    = CSR_DATA_W'($urandom_range(1500, 5000));
      margin = CSR_DATA_W'($urandom_range(0, 800));
      min_i  = CSR_DATA_W'($urandom_range(20, 400));
      max_i  = CSR_DATA_W'($urandom_range(600, 4000));
      idle   = CSR_DATA_W'($urandom_range(300, 4000));
      // now and then a register anywhere in its range
      if ($urandom_range(0, 5) == 0)
         thr = CSR_DATA_W'($urandom);
      if ($urandom_range(0, 5) == 0)
         margin = CSR_DATA_W'($urandom);
      if ($urandom_range(0, 5) == 0)
         min_i = CSR_DATA_W'($urandom_range(1, 16'hFFFF));
      if ($urandom_range(0, 5) == 0)
         max_i = CSR_DATA_W'($urandom_range(1, 16'hFFFF));
      if ($urandom_range(0, 5) == 0)
         idle = CSR_DATA_W'($urandom_range(1, 16'hFFFF));
      program_regs(thr, margin, min_i, max_i, idle);
   endtask

   // Bulk of the run: walking at varied cadence under random settings and idling.
   task automatic test_random_walk();
      repeat (RANDOM_PHASES) begin
         program_random_regs();
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0)
            walk_time = TIME_NEAR_WRAP - $urandom_range(0, 5000);
         else
            walk_time = $urandom;
         walk_items(ITEMS_PER_PHASE, 2, 20, 150, 1500, 10);
         wait_drain();
      end
   endtask

   initial begin : run_tests
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_backpressure();
      test_random_walk();

      wait_drain();
      repeat (END_SETTLE) @(posedge clock);
      if (report_q.size() != 0)
         flag_error($sformatf("%0d results never arrived", report_q.size()));
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", report_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
